// ===== sv/kbml_pkg.sv =====
// ----------------------------------------------------------------------------
// kbml_pkg
// Shared codes and types of the k best match list: action codes of an input
// transaction and the control bundle handed to every list cell.
// ----------------------------------------------------------------------------
package kbml_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    typedef struct packed {
        logic ins;      // insert strobe for this cycle
        logic prev_gt;  // left neighbor holds a distance above the candidate
    } kbml_cell_ctl_t;

endpackage

// ===== sv/kbml_cell.sv =====
// ----------------------------------------------------------------------------
// kbml_cell
// One slot of the sorted list. Holds one entry and, on insert, keeps it,
// takes the candidate or takes the left neighbor's entry.
// ----------------------------------------------------------------------------
module kbml_cell #(
    parameter int IDX = 0,
    parameter int CB  = 12,
    parameter int DB  = 22,
    parameter int NB  = 8
) (
    input  logic                    clk,
    input  kbml_pkg::kbml_cell_ctl_t ctl,
    input  logic [NB-1:0]           count,
    input  logic [2*CB+DB-1:0]      cand_ent,
    input  logic [2*CB+DB-1:0]      prev_ent,
    output logic [2*CB+DB-1:0]      ent,
    output logic                    gt
);
    import kbml_pkg::*;

    localparam int EW = 2*CB + DB;

    logic [EW-1:0] ent_reg;
    logic [EW-1:0] ent_next;
    logic          in_use;
    logic          at_count;

    assign in_use   = count > NB'(IDX);
    assign at_count = count == NB'(IDX);
    assign gt       = in_use && (ent_reg[EW-1:2*CB] > cand_ent[EW-1:2*CB]);
    assign ent      = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.ins)
        begin
            if (ctl.prev_gt)
                ent_next = prev_ent;          // shift right by one slot
            else if (gt || at_count)
                ent_next = cand_ent;          // candidate lands here
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

// ===== sv/k_best_match_list.sv =====
// Timing: insert and clear give their result in the cycle after acceptance; a
//   read passes ST_GRP and ST_OUT first (two registered select stages).
// Throughput: one insert or clear per cycle while the result is taken; a read
//   blocks input in ST_GRP and ST_OUT. All cells handle each insert in parallel.
// Reset: the entry count clears to zero at once; cell contents stay undefined
//   until written and need no clearing pass.
// ----------------------------------------------------------------------------
// k_best_match_list
// Bounded list of the best candidate patches sorted by ascending distance,
// built as a row of cells that each compare the candidate and shift right.
// ----------------------------------------------------------------------------
module k_best_match_list #(
    parameter int CAPACITY   = 128,
    parameter int COORD_BITS = 12,
    parameter int DIST_BITS  = 22,
    localparam int IB     = $clog2(CAPACITY),
    localparam int NB     = $clog2(CAPACITY + 1),
    localparam int IN_W   = ((2*COORD_BITS + DIST_BITS + IB + 7) / 8) * 8,
    localparam int OUT_W  = ((2*COORD_BITS + DIST_BITS + NB + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // s_tdata, from bit 0: cand_x, cand_y, cand_dist, read_index, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    // s_tuser: action
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // m_tdata, from bit 0: entry_x, entry_y, entry_dist, entry_count, zero pad
    output logic [OUT_W-1:0] m_tdata,
    // m_tuser: entry_valid
    output logic             m_tuser
);
    import kbml_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DB    = DIST_BITS;
    localparam int EW    = 2*CB + DB;
    // read select: groups of up to 16 cells, then the group
    localparam int GB    = (IB < 4) ? IB : 4;
    localparam int GROUP = 1 << GB;
    localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;
    localparam int GSB   = (NGRP > 1) ? $clog2(NGRP) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_GRP, ST_OUT} state_t;

    state_t          state_reg;
    logic [NB-1:0]   count_reg;
    logic [NB-1:0]   count_next;
    logic [IB-1:0]   rd_idx_reg;
    logic            s_fire;
    logic            ins;
    logic            out_load;
    logic [EW-1:0]   cand_ent;
    logic [IB-1:0]   in_idx;

    logic [EW-1:0]   cell_ent [CAPACITY];
    logic            cell_gt  [CAPACITY];
    logic [EW-1:0]   cell_grid [NGRP][GROUP];
    logic [EW-1:0]   grp_next  [NGRP];
    logic [EW-1:0]   grp_reg   [NGRP];
    logic [GSB-1:0]  grp_sel;
    logic [EW-1:0]   rd_ent;
    logic            rd_valid;

    // accept only while idle and with the output register free
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid || m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign ins      = s_fire && (s_tuser == ACT_INSERT);
    assign cand_ent = s_tdata[EW-1:0];
    assign in_idx   = s_tdata[EW+IB-1:EW];

    // a new result enters the output register on any non-read transaction,
    // or when a read leaves its select stages
    assign out_load = (s_fire && (s_tuser != ACT_READ)) || (state_reg == ST_OUT);

    // grow the count on insert until full; a full list keeps its count
    always_comb
    begin
        count_next = count_reg;
        if (ins && (count_reg != NB'(CAPACITY)))
            count_next = count_reg + NB'(1);
    end

    // ---- row of cells ------------------------------------------------------
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            kbml_cell_ctl_t ctl;
            logic           prev_gt;
            logic [EW-1:0]  prev_ent;
            if (i == 0)
            begin : g_first
                assign prev_gt  = 1'b0;
                assign prev_ent = cand_ent;
            end
            else
            begin : g_rest
                assign prev_gt  = cell_gt[i-1];
                assign prev_ent = cell_ent[i-1];
            end
            assign ctl = '{ins: ins, prev_gt: prev_gt};

            kbml_cell #(
                .IDX (i),
                .CB  (CB),
                .DB  (DB),
                .NB  (NB)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .count    (count_reg),
                .cand_ent (cand_ent),
                .prev_ent (prev_ent),
                .ent      (cell_ent[i]),
                .gt       (cell_gt[i])
            );
        end

        // lay the cells out as groups; pad slots past the capacity with zeros
        for (i = 0; i < NGRP*GROUP; i++)
        begin : g_grid
            if (i < CAPACITY)
            begin : g_used
                assign cell_grid[i/GROUP][i%GROUP] = cell_ent[i];
            end
            else
            begin : g_pad
                assign cell_grid[i/GROUP][i%GROUP] = '0;
            end
        end

        // first select stage: the cell inside each group
        for (i = 0; i < NGRP; i++)
        begin : g_grp
            assign grp_next[i] = cell_grid[i][rd_idx_reg[GB-1:0]];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GRP)
            grp_reg <= grp_next;
    end

    // second select stage: the group
    assign grp_sel  = GSB'(rd_idx_reg >> GB);
    assign rd_valid = NB'(rd_idx_reg) < count_reg;
    assign rd_ent   = rd_valid ? grp_reg[grp_sel] : '0;

    // ---- control and output register ---------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            m_tvalid   <= 1'b0;
            m_tdata    <= '0;
            m_tuser    <= 1'b0;
        end
        else
        begin
            // load a new result, or drop the current one once taken
            if (out_load)
                m_tvalid <= 1'b1;
            else if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        unique case (s_tuser)
                            ACT_INSERT:
                            begin
                                count_reg <= count_next;
                                m_tdata   <= OUT_W'({count_next, {EW{1'b0}}});
                                m_tuser   <= 1'b0;
                            end
                            ACT_CLEAR:
                            begin
                                count_reg <= '0;
                                m_tdata   <= '0;
                                m_tuser   <= 1'b0;
                            end
                            ACT_READ:
                            begin
                                rd_idx_reg <= in_idx;
                                state_reg  <= ST_GRP;
                            end
                            default:
                            begin
                                // unused code: report the count only
                                m_tdata  <= OUT_W'({count_reg, {EW{1'b0}}});
                                m_tuser  <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_GRP:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // output register is free: it was free at acceptance
                    m_tdata   <= OUT_W'({count_reg, rd_ent});
                    m_tuser   <= rd_valid;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/kbml_checker.sv =====
// ----------------------------------------------------------------------------
// kbml_checker
// Port-level checks of the k best match list, bound to the top level.
// ----------------------------------------------------------------------------
module kbml_checker #(
    parameter int CAPACITY   = 128,
    parameter int COORD_BITS = 12,
    parameter int DIST_BITS  = 22,
    localparam int NB    = $clog2(CAPACITY + 1),
    localparam int EW    = 2*COORD_BITS + DIST_BITS,
    localparam int OUT_W = ((EW + NB + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [1:0]       s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);
    import kbml_pkg::*;

    logic [NB-1:0] out_count;
    assign out_count = m_tdata[EW+NB-1:EW];

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a clear reports an empty list in the next cycle
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_CLEAR)
        |=> m_tvalid && (m_tdata == '0) && !m_tuser)
        else $error("clear result wrong");

    // an insert reports a non-empty list and no entry in the next cycle
    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_INSERT)
        |=> m_tvalid && !m_tuser && (m_tdata[EW-1:0] == '0) && (out_count != '0))
        else $error("insert result wrong");

    // a valid entry implies a non-empty list within capacity
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (out_count != '0) && (out_count <= NB'(CAPACITY)))
        else $error("valid entry with bad count");

endmodule

bind k_best_match_list kbml_checker #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS),
    .DIST_BITS  (DIST_BITS)
) u_kbml_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k best match list: a scoreboard keeps its own
// sorted copy of the list, predicts every result, and compares it field by
// field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    import kbml_pkg::*;

    // One predicted result transaction of the list
    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [21:0] distance;
        logic        valid;
        logic [7:0]  count;
    } list_reply_t;

    // Mirror of the sorted list plus the queue of results still owed by the block
    class best_match_tracker;
        localparam int DEPTH = 128;

        logic [11:0] col_mem  [DEPTH];
        logic [11:0] row_mem  [DEPTH];
        logic [21:0] dist_mem [DEPTH];
        int unsigned held;
        list_reply_t owed_replies[$];
        int unsigned mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return owed_replies.size();
        endfunction

        function logic [21:0] worst_dist();
            return (held == 0) ? 22'd0 : dist_mem[held-1];
        endfunction

        // Update the mirror with an accepted input transaction and queue its result
        function void record_request(logic [1:0] act, logic [11:0] x, logic [11:0] y,
                                     logic [21:0] d, logic [6:0] idx);
            list_reply_t r;
            int          pos;
            int          last;
            bit          take;
            r    = '{x: '0, y: '0, distance: '0, valid: 1'b0, count: '0};
            take = 1'b0;
            last = 0;
            case (act)
                ACT_INSERT:
                begin
                    pos = 0;
                    // new entry lands after every held entry of equal distance
                    while (pos < held && dist_mem[pos] <= d)
                        pos++;
                    if (held < DEPTH)
                    begin
                        last = held;
                        take = 1'b1;
                        held++;
                    end
                    else if (d < dist_mem[DEPTH-1])
                    begin
                        // full: drop the worst entry
                        last = DEPTH - 1;
                        take = 1'b1;
                    end
                    if (take)
                    begin
                        for (int i = last; i > pos; i--)
                        begin
                            col_mem[i]  = col_mem[i-1];
                            row_mem[i]  = row_mem[i-1];
                            dist_mem[i] = dist_mem[i-1];
                        end
                        col_mem[pos]  = x;
                        row_mem[pos]  = y;
                        dist_mem[pos] = d;
                    end
                end
                ACT_CLEAR:
                    held = 0;
                ACT_READ:
                    if (idx < held)
                    begin
                        r.x        = col_mem[idx];
                        r.y        = row_mem[idx];
                        r.distance = dist_mem[idx];
                        r.valid    = 1'b1;
                    end
                default:
                    ; // unused code: state untouched, reply as an out-of-range read
            endcase
            r.count = held[7:0];
            owed_replies = {owed_replies, r};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare an accepted result transaction against the oldest prediction
        function void check_response(logic [55:0] data, logic flag);
            list_reply_t e;
            if (owed_replies.size() == 0)
            begin
                $error("unexpected result transaction: tdata %h tuser %b", data, flag);
                mismatches++;
                return;
            end
            e = owed_replies.pop_front();
            compare_field("entry_x",     32'(e.x),        32'(data[11:0]));
            compare_field("entry_y",     32'(e.y),        32'(data[23:12]));
            compare_field("entry_dist",  32'(e.distance), 32'(data[45:24]));
            compare_field("entry_count", 32'(e.count),    32'(data[53:46]));
            compare_field("entry_valid", 32'(e.valid),    32'(flag));
        endfunction
    endclass

    localparam logic [1:0] ACT_UNUSED = 2'd3;  // no operation assigned
    localparam int         LIST_DEPTH = 128;
    localparam int         QUIET_LIMIT = 4000; // cycles without any transaction
    localparam logic [21:0] DIST_MAX  = 22'h3FFFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = ACT_INSERT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    best_match_tracker sb;
    int unsigned       items_sent = 0;
    int unsigned       idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
    int unsigned       quiet_cycles = 0;

    k_best_match_list DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure follows the current idling phase
    always @(posedge clk)
    begin
        case (idle_mode)
            2:       m_tready <= ($urandom_range(99) >= 87);
            3:       m_tready <= ($urandom_range(99) >= 36);
            default: m_tready <= 1'b1;
        endcase
    end

    // Check every result transaction; outputs are read before this edge's updates
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_response(m_tdata, m_tuser);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic bit sender_rests();
        case (idle_mode)
            1:       return $urandom_range(99) < 87;
            3:       return $urandom_range(99) < 36;
            default: return 1'b0;
        endcase
    endfunction

    // Present one transaction and hold it until the block takes it
    task automatic send_item(input logic [1:0] act, input logic [11:0] x,
                             input logic [11:0] y, input logic [21:0] d,
                             input logic [6:0] idx);
        while (sender_rests())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, idx, d, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.record_request(act, x, y, d, idx);
        if (act != ACT_UNUSED)
            items_sent++;
        // rotate the idling phase every 64 transactions, not counting unused codes
        idle_mode = (items_sent / 64) % 4;
    endtask

    // Drop valid and hold off until every owed result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    function automatic logic [6:0] pick_index();
        if ($urandom_range(1) == 0 || sb.held == 0)
            return 7'($urandom_range(127));
        return 7'($urandom_range(sb.held - 1));
    endfunction

    // Clear, then stream mostly inserts with reads mixed in so the list fills,
    // overflows and keeps rejecting; a narrow span forces many equal distances.
    task automatic fill_and_probe(input int n_items, input int unsigned span);
        int          done;
        int unsigned r;
        logic [21:0] d;
        done = 0;
        send_item(ACT_CLEAR, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                  22'($urandom_range(DIST_MAX)), 7'($urandom_range(127)));
        while (done < n_items)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                if (sb.held == LIST_DEPTH && $urandom_range(3) == 0)
                    d = sb.worst_dist() - 22'($urandom_range(1)); // tie or just below
                else
                    d = 22'($urandom_range(span));
                send_item(ACT_INSERT, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                          d, 7'($urandom_range(127)));
                done++;
            end
            else if (r < 92)
            begin
                send_item(ACT_READ, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                          22'($urandom_range(DIST_MAX)), pick_index());
                done++;
            end
            else if (r < 95)
            begin
                // noise: unused code, leaves the list unchanged and gets a count-only reply
                send_item(ACT_UNUSED, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                          22'($urandom_range(DIST_MAX)), 7'($urandom_range(127)));
            end
            else
            begin
                d = $urandom_range(1) ? DIST_MAX : 22'd0;
                send_item(ACT_INSERT, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                          d, 7'($urandom_range(127)));
                done++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, extremes, ties at both ends, range edges, clear
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd0);
        send_item(ACT_UNUSED, 12'hFFF,  12'hFFF,  DIST_MAX, 7'h7F);
        send_item(ACT_INSERT, 12'd0,    12'd0,    22'd0,    7'd0);
        send_item(ACT_INSERT, 12'hFFF,  12'hFFF,  DIST_MAX, 7'h7F);
        send_item(ACT_INSERT, 12'd5,    12'd6,    DIST_MAX, 7'd0);
        send_item(ACT_INSERT, 12'd1,    12'd2,    22'd0,    7'd0);
        send_item(ACT_INSERT, 12'hA5A,  12'h5A5,  22'h2AAAAA, 7'h55);
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd0);
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd1);
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd2);
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd3);
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd4);
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd5);
        send_item(ACT_READ,   12'hFFF,  12'hFFF,  DIST_MAX, 7'h7F);
        send_item(ACT_UNUSED, 12'd3,    12'd4,    22'd9,    7'd0);
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd0);
        send_item(ACT_CLEAR,  12'hFFF,  12'hFFF,  DIST_MAX, 7'h7F);
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd0);
        send_item(ACT_INSERT, 12'h123,  12'h456,  22'h1FFFFF, 7'd0);
        send_item(ACT_READ,   12'd0,    12'd0,    22'd0,    7'd0);
        send_item(ACT_CLEAR,  12'd0,    12'd0,    22'd0,    7'd0);

        // Random: several fill passes with different distance spans
        fill_and_probe(205, 15);
        fill_and_probe(205, 32'(DIST_MAX));
        drain_results();
        fill_and_probe(205, 255);
        fill_and_probe(205, 63);
        fill_and_probe(210, 32'(DIST_MAX));

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/kbml_pkg.sv
sv/kbml_cell.sv
sv/k_best_match_list.sv
sv/kbml_checker.sv
sim/tb_top.sv
